FILE: hw/rtl/eadfr_pkg.sv
// Shared types and constants for the ENQ/ACK DLE frame receiver.
// Used by the register block, the receive core, the result buffer and the checker.
// No dependencies.
package eadfr_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_DLE = 8'h10;
  localparam logic [7:0] CH_ETX = 8'h03;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [7:0]  LIMIT_RESET   = 8'd128;

  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_LIMIT   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RECV  = 2'd1,
    PH_ACKED = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DELIVERED = 3'd1,
    EV_BADCHECK  = 3'd2,
    EV_OVERFLOW  = 3'd3,
    EV_TIMEOUT   = 3'd4
  } event_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  frame_limit;
  } cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    event_t     event_res;
    logic [7:0] frame_length;
  } res_t;

endpackage

FILE: hw/rtl/eadfr_regs.sv
// Configuration registers behind the APB-style port.
// Depends on eadfr_pkg.
module eadfr_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [eadfr_pkg::ADDR_W-1:0]    paddr,
  input  logic [eadfr_pkg::DATA_W-1:0]    pwdata,
  output logic [eadfr_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  output eadfr_pkg::cfg_t                 cfg
);

  eadfr_pkg::reg_idx_t idx;
  logic                wr_en;

  assign idx    = eadfr_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= eadfr_pkg::TIMEOUT_RESET;
      cfg.frame_limit   <= eadfr_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        eadfr_pkg::REG_TIMEOUT: cfg.timeout_ticks <= pwdata[15:0];
        eadfr_pkg::REG_LIMIT:   cfg.frame_limit   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      eadfr_pkg::REG_TIMEOUT: prdata = {16'd0, cfg.timeout_ticks};
      eadfr_pkg::REG_LIMIT:   prdata = {24'd0, cfg.frame_limit};
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/eadfr_core.sv
// Receive state machine: ENQ handshake, DLE unescaping, XOR check, timeouts.
// Produces one result per accepted beat. Depends on eadfr_pkg.
module eadfr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              mode,
  input  logic [7:0]        rx_byte,
  input  eadfr_pkg::cfg_t   cfg,
  output eadfr_pkg::res_t   res
);

  eadfr_pkg::phase_t phase, phase_next;
  logic        escape_pending, escape_pending_next;
  logic        end_seen, end_seen_next;
  logic [7:0]  check_xor, check_xor_next;
  logic [7:0]  stored_count, stored_count_next;
  logic [15:0] silence_ticks, silence_ticks_next;

  logic [15:0] sil_inc;
  logic        timed_out;
  logic [7:0]  xor_upd;
  logic [7:0]  cnt_inc;
  logic        overflow;
  logic        is_dle_start;
  logic        is_etx_end;

  assign sil_inc      = silence_ticks + 16'd1;
  assign timed_out    = sil_inc >= cfg.timeout_ticks;
  assign xor_upd      = (stored_count != 8'd0) ? (check_xor ^ rx_byte) : check_xor;
  assign cnt_inc      = stored_count + 8'd1;
  assign overflow     = cnt_inc >= cfg.frame_limit;
  assign is_dle_start = !escape_pending && (rx_byte == eadfr_pkg::CH_DLE);
  assign is_etx_end   = !escape_pending && (rx_byte == eadfr_pkg::CH_ETX);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= eadfr_pkg::PH_IDLE;
      escape_pending <= 1'b0;
      end_seen       <= 1'b0;
      check_xor      <= 8'd0;
      stored_count   <= 8'd0;
      silence_ticks  <= 16'd0;
    end else if (accept) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      end_seen       <= end_seen_next;
      check_xor      <= check_xor_next;
      stored_count   <= stored_count_next;
      silence_ticks  <= silence_ticks_next;
    end
  end

  // Next state
  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    end_seen_next       = end_seen;
    check_xor_next      = check_xor;
    stored_count_next   = stored_count;
    silence_ticks_next  = silence_ticks;
    unique case (phase)
      eadfr_pkg::PH_RECV, eadfr_pkg::PH_ACKED: begin
        if (mode) begin
          silence_ticks_next = sil_inc;
          if (timed_out) phase_next = eadfr_pkg::PH_IDLE;
        end else if (phase == eadfr_pkg::PH_ACKED) begin
          phase_next = eadfr_pkg::PH_IDLE;
        end else begin
          silence_ticks_next = 16'd0;
          check_xor_next     = xor_upd;
          if (end_seen) begin
            phase_next = (xor_upd == 8'd0) ? eadfr_pkg::PH_ACKED : eadfr_pkg::PH_IDLE;
          end else if (is_dle_start) begin
            escape_pending_next = 1'b1;
          end else begin
            if (is_etx_end) end_seen_next = 1'b1;
            escape_pending_next = 1'b0;
            stored_count_next   = cnt_inc;
            if (overflow) phase_next = eadfr_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        // Idle, and the unused code: only ENQ opens a frame
        if (!mode && rx_byte == eadfr_pkg::CH_ENQ) begin
          phase_next          = eadfr_pkg::PH_RECV;
          escape_pending_next = 1'b0;
          end_seen_next       = 1'b0;
          check_xor_next      = 8'd0;
          stored_count_next   = 8'd0;
          silence_ticks_next  = 16'd0;
        end
      end
    endcase
  end

  // Result of the current beat
  always_comb begin
    res = '0;
    unique case (phase)
      eadfr_pkg::PH_RECV, eadfr_pkg::PH_ACKED: begin
        if (mode) begin
          if (timed_out) begin
            if (phase == eadfr_pkg::PH_ACKED) begin
              res.event_res    = eadfr_pkg::EV_DELIVERED;
              res.frame_length = stored_count;
            end else begin
              res.event_res = eadfr_pkg::EV_TIMEOUT;
            end
          end
        end else if (phase == eadfr_pkg::PH_ACKED) begin
          res.event_res    = eadfr_pkg::EV_DELIVERED;
          res.frame_length = stored_count;
        end else if (end_seen) begin
          res.tx_valid = 1'b1;
          if (xor_upd == 8'd0) begin
            res.tx_byte = eadfr_pkg::CH_ACK;
          end else begin
            res.tx_byte   = eadfr_pkg::CH_NAK;
            res.event_res = eadfr_pkg::EV_BADCHECK;
          end
        end else if (!is_dle_start) begin
          res.data_valid = 1'b1;
          res.data_byte  = rx_byte;
          if (overflow) begin
            res.tx_valid  = 1'b1;
            res.tx_byte   = eadfr_pkg::CH_NAK;
            res.event_res = eadfr_pkg::EV_OVERFLOW;
          end
        end
      end
      default: begin
        if (!mode && rx_byte == eadfr_pkg::CH_ENQ) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = eadfr_pkg::CH_ACK;
        end
      end
    endcase
  end

endmodule

FILE: hw/rtl/eadfr_outbuf.sv
// Two-entry result buffer: output register plus skid register.
// Keeps the input side open while one result waits. Depends on eadfr_pkg.
module eadfr_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  eadfr_pkg::res_t   push_res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output eadfr_pkg::res_t   out_res
);

  logic            skid_valid;
  eadfr_pkg::res_t skid_res;
  logic            pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) skid_valid <= 1'b1;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: skid into output, new beat into output, or a stalled beat into the skid
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_res <= skid_res;
    end else if (push) begin
      if (out_valid && !pop) skid_res <= push_res;
      else                   out_res  <= push_res;
    end
  end

endmodule

FILE: hw/rtl/enq_ack_dle_frame_receiver.sv
// ENQ/ACK frame receiver with DLE unescaping and XOR block check. Each beat
// (a received byte or a timer tick) yields exactly one result beat, held in
// the result buffer. One beat per cycle is taken for as long as results drain;
// a two-entry result buffer sets the stall behavior: item_ready drops only
// when both the output register and the skid register hold a result.
// Depends on eadfr_pkg, eadfr_regs, eadfr_core and eadfr_outbuf.
module enq_ack_dle_frame_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          mode,
  input  logic [7:0]                    rx_byte,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          tx_valid,
  output logic [7:0]                    tx_byte,
  output logic                          data_valid,
  output logic [7:0]                    data_byte,
  output logic [2:0]                    event_res,
  output logic [7:0]                    frame_length,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eadfr_pkg::ADDR_W-1:0]  paddr,
  input  logic [eadfr_pkg::DATA_W-1:0]  pwdata,
  output logic [eadfr_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  eadfr_pkg::cfg_t cfg;
  eadfr_pkg::res_t core_res;
  eadfr_pkg::res_t out_res;
  logic            accept;

  assign accept = item_valid && item_ready;

  eadfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eadfr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .mode    (mode),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (core_res)
  );

  eadfr_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_res  (core_res),
    .space     (item_ready),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_res   (out_res)
  );

  assign tx_valid     = out_res.tx_valid;
  assign tx_byte      = out_res.tx_byte;
  assign data_valid   = out_res.data_valid;
  assign data_byte    = out_res.data_byte;
  assign event_res    = out_res.event_res;
  assign frame_length = out_res.frame_length;

endmodule

FILE: hw/rtl/eadfr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
// Depends on eadfr_pkg and enq_ack_dle_frame_receiver.
module eadfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       data_valid,
  input logic [2:0] event_res,
  input logic [7:0] frame_length
);

  // Input side closes only behind a stalled result
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(item_ready) |-> $past(res_valid && !res_ready))
    else $error("item_ready dropped without a stalled result");

  // A full buffer always shows a result
  a_full_shows: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> res_valid)
    else $error("buffer full but no result shown");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_res == eadfr_pkg::EV_OVERFLOW) |->
      (tx_valid && tx_byte == eadfr_pkg::CH_NAK && data_valid))
    else $error("overflow result without NAK and stored byte");

  a_length: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_res != eadfr_pkg::EV_DELIVERED) |-> (frame_length == 8'd0))
    else $error("frame length outside a delivery");

endmodule

bind enq_ack_dle_frame_receiver eadfr_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .res_valid    (res_valid),
  .res_ready    (res_ready),
  .tx_valid     (tx_valid),
  .tx_byte      (tx_byte),
  .data_valid   (data_valid),
  .event_res    (event_res),
  .frame_length (frame_length)
);

FILE: dv/tb.sv
// Self-checking testbench for enq_ack_dle_frame_receiver: a directed table, then
// random framed traffic, checked beat by beat against an in-bench frame predictor
// or a pinned expectation. Depends on eadfr_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx;
  } rx_item_t;

  typedef struct packed {
    logic            mode;
    logic [7:0]      rx;
    logic            pinned;
    eadfr_pkg::res_t want;
  } dir_row_t;

  localparam eadfr_pkg::res_t NO_REPLY = '0;
  localparam eadfr_pkg::res_t ACK_ONLY =
    '{1'b1, eadfr_pkg::CH_ACK, 1'b0, 8'h00, eadfr_pkg::EV_NONE, 8'h00};
  localparam int unsigned DIR_ROWS = 25;
  localparam int unsigned PHASE_B_AT = 15;
  localparam int unsigned SEG_ITEMS = 85;
  localparam int unsigned LONG_HOLD = 300;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          item_valid = 1'b0;
  logic                          item_ready;
  logic                          mode = 1'b0;
  logic [7:0]                    rx_byte = 8'h00;
  logic                          res_valid;
  logic                          res_ready = 1'b0;
  logic                          tx_valid;
  logic [7:0]                    tx_byte;
  logic                          data_valid;
  logic [7:0]                    data_byte;
  logic [2:0]                    event_res;
  logic [7:0]                    frame_length;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [eadfr_pkg::ADDR_W-1:0]  paddr = '0;
  logic [eadfr_pkg::DATA_W-1:0]  pwdata = '0;
  logic [eadfr_pkg::DATA_W-1:0]  prdata;
  logic                          pready;

  // pinned expectation travels with the payload of a directed beat
  logic                pin_on = 1'b0;
  eadfr_pkg::res_t     pin_res = '0;

  int unsigned         send_idle_pct = 13;
  int unsigned         recv_idle_pct = 87;
  logic                long_hold_arm = 1'b0;
  logic                hold_taken = 1'b0;
  int unsigned         hold_left = 0;

  // frame predictor state and register copy
  eadfr_pkg::phase_t   rx_phase = eadfr_pkg::PH_IDLE;
  logic                esc_pend = 1'b0;
  logic                etx_seen = 1'b0;
  logic [7:0]          run_xor = 8'h00;
  logic [7:0]          stored_n = 8'h00;
  logic [15:0]         quiet_ticks = 16'h0000;
  logic [15:0]         cfg_timeout = eadfr_pkg::TIMEOUT_RESET;
  logic [7:0]          cfg_limit = eadfr_pkg::LIMIT_RESET;

  eadfr_pkg::res_t     pending_replies[$];
  rx_item_t            plan_q[$];
  int unsigned         fault_count = 0;
  int unsigned         beats_in = 0;
  int unsigned         replies_checked = 0;
  int unsigned         reg_settings = 0;
  int unsigned         ev_count[0:4] = '{default: 0};

  enq_ack_dle_frame_receiver DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .mode         (mode),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .data_valid   (data_valid),
    .data_byte    (data_byte),
    .event_res    (event_res),
    .frame_length (frame_length),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  initial begin
    #10ms;
    $display("** enq_ack_dle_frame_receiver: FAILED **");
    $finish;
  end

  function automatic void log_fault(input string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endfunction

  function automatic eadfr_pkg::res_t rx_frame_predict(input logic is_tick,
                                                       input logic [7:0] b);
    eadfr_pkg::res_t r;
    r = '0;
    if (rx_phase == eadfr_pkg::PH_RECV || rx_phase == eadfr_pkg::PH_ACKED) begin
      if (is_tick) begin
        quiet_ticks = quiet_ticks + 16'd1;
        if (quiet_ticks >= cfg_timeout) begin
          if (rx_phase == eadfr_pkg::PH_ACKED) begin
            r.event_res = eadfr_pkg::EV_DELIVERED;
            r.frame_length = stored_n;
          end else begin
            r.event_res = eadfr_pkg::EV_TIMEOUT;
          end
          rx_phase = eadfr_pkg::PH_IDLE;
        end
      end else if (rx_phase == eadfr_pkg::PH_ACKED) begin
        // any byte after ACK hands the frame over
        r.event_res = eadfr_pkg::EV_DELIVERED;
        r.frame_length = stored_n;
        rx_phase = eadfr_pkg::PH_IDLE;
      end else begin
        quiet_ticks = 16'h0000;
        if (stored_n != 8'h00) run_xor = run_xor ^ b;
        if (etx_seen) begin
          r.tx_valid = 1'b1;
          if (run_xor == 8'h00) begin
            r.tx_byte = eadfr_pkg::CH_ACK;
            rx_phase = eadfr_pkg::PH_ACKED;
          end else begin
            r.tx_byte = eadfr_pkg::CH_NAK;
            r.event_res = eadfr_pkg::EV_BADCHECK;
            rx_phase = eadfr_pkg::PH_IDLE;
          end
        end else if (!esc_pend && b == eadfr_pkg::CH_DLE) begin
          esc_pend = 1'b1;
        end else begin
          if (!esc_pend && b == eadfr_pkg::CH_ETX) etx_seen = 1'b1;
          esc_pend = 1'b0;
          r.data_valid = 1'b1;
          r.data_byte = b;
          stored_n = stored_n + 8'd1;
          if (stored_n >= cfg_limit) begin
            r.tx_valid = 1'b1;
            r.tx_byte = eadfr_pkg::CH_NAK;
            r.event_res = eadfr_pkg::EV_OVERFLOW;
            rx_phase = eadfr_pkg::PH_IDLE;
          end
        end
      end
    end else if (!is_tick && b == eadfr_pkg::CH_ENQ) begin
      r.tx_valid = 1'b1;
      r.tx_byte = eadfr_pkg::CH_ACK;
      rx_phase = eadfr_pkg::PH_RECV;
      esc_pend = 1'b0;
      etx_seen = 1'b0;
      run_xor = 8'h00;
      stored_n = 8'h00;
      quiet_ticks = 16'h0000;
    end
    return r;
  endfunction

  // compare the oldest expectation first, then queue the one for this edge's beat
  always @(posedge clk) begin : scoreboard
    eadfr_pkg::res_t want;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (pending_replies.size() == 0) begin
          log_fault($sformatf("unexpected result beat: tx %0b/%02h data %0b/%02h ev %0d len %0d",
                              tx_valid, tx_byte, data_valid, data_byte, event_res,
                              frame_length));
        end else begin
          want = pending_replies.pop_front();
          if (tx_valid !== want.tx_valid || tx_byte !== want.tx_byte ||
              data_valid !== want.data_valid || data_byte !== want.data_byte ||
              event_res !== want.event_res || frame_length !== want.frame_length) begin
            log_fault($sformatf(
              "result %0d: expected tx %0b/%02h data %0b/%02h ev %0d len %0d",
              replies_checked, want.tx_valid, want.tx_byte, want.data_valid,
              want.data_byte, want.event_res, want.frame_length));
            if (fault_count <= 10)
              $display("  got tx %0b/%02h data %0b/%02h ev %0d len %0d", tx_valid, tx_byte,
                       data_valid, data_byte, event_res, frame_length);
          end
          replies_checked++;
        end
      end
      if (item_valid && item_ready) begin
        want = rx_frame_predict(mode, rx_byte);
        if (pin_on) want = pin_res;
        ev_count[int'(want.event_res)]++;
        pending_replies.push_back(want);
        beats_in++;
      end
    end
  end

  // result sink: random stalls, plus one long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (long_hold_arm && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic m, input logic [7:0] b, input logic pinned,
                           input eadfr_pkg::res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    rx_byte <= b;
    pin_on <= pinned;
    pin_res <= want;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(input eadfr_pkg::reg_idx_t idx, input logic [31:0] val);
    logic [31:0] seen;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    seen = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      eadfr_pkg::REG_TIMEOUT: begin
        cfg_timeout = val[15:0];
        if (seen[15:0] !== val[15:0])
          log_fault($sformatf("timeout readback: expected %0d got %0d", val[15:0], seen[15:0]));
      end
      eadfr_pkg::REG_LIMIT: begin
        cfg_limit = val[7:0];
        if (seen[7:0] !== val[7:0])
          log_fault($sformatf("limit readback: expected %0d got %0d", val[7:0], seen[7:0]));
      end
      default: ;
    endcase
    reg_settings++;
  endtask

  // mostly well-formed frames with random content; the rest noise and broken frames
  task automatic plan_frame();
    int unsigned roll;
    int unsigned n;
    int unsigned k;
    int unsigned kept;
    logic [7:0]  b;
    logic [7:0]  sum;
    roll = $urandom_range(99);
    if (roll < 12) begin
      plan_q.push_back(rx_item_t'{1'($urandom_range(1)), 8'($urandom)});
      return;
    end
    plan_q.push_back(rx_item_t'{1'b0, eadfr_pkg::CH_ENQ});
    // leave the frame open for whatever comes next
    if (roll < 16) return;
    n = ($urandom_range(24) == 0) ? cfg_limit - $urandom_range(1) : $urandom_range(10);
    kept = 0;
    sum = 8'h00;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: b = eadfr_pkg::CH_DLE;
        1: b = eadfr_pkg::CH_ETX;
        2: b = ($urandom_range(1) != 0) ? 8'h00 : 8'hFF;
        default: b = 8'($urandom);
      endcase
      if ($urandom_range(15) == 0) plan_q.push_back(rx_item_t'{1'b1, 8'($urandom)});
      // escape control bytes most of the time; a raw one breaks the frame
      if ((b == eadfr_pkg::CH_DLE || b == eadfr_pkg::CH_ETX) && $urandom_range(7) != 0) begin
        if (kept != 0) sum = sum ^ eadfr_pkg::CH_DLE;
        plan_q.push_back(rx_item_t'{1'b0, eadfr_pkg::CH_DLE});
      end
      if (kept != 0) sum = sum ^ b;
      kept++;
      plan_q.push_back(rx_item_t'{1'b0, b});
    end
    if (kept != 0) sum = sum ^ eadfr_pkg::CH_ETX;
    plan_q.push_back(rx_item_t'{1'b0, eadfr_pkg::CH_ETX});
    if ($urandom_range(6) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    plan_q.push_back(rx_item_t'{1'b0, sum});
    roll = $urandom_range(9);
    if (roll < 4 && cfg_timeout <= 40) begin
      for (k = 0; k < cfg_timeout; k++) plan_q.push_back(rx_item_t'{1'b1, 8'($urandom)});
    end else if (roll < 8) begin
      plan_q.push_back(rx_item_t'{1'b0, 8'($urandom)});
    end
  endtask

  initial begin : main
    dir_row_t    directed[DIR_ROWS];
    rx_item_t    it;
    int unsigned i;
    int unsigned seg;
    int unsigned cnt;
    logic [15:0] t_val;
    logic [7:0]  l_val;

    // reset values: timeout 500, limit 128
    directed[0]  = '{1'b1, 8'h00, 1'b1, NO_REPLY};
    directed[1]  = '{1'b0, 8'hFF, 1'b1, NO_REPLY};
    directed[2]  = '{1'b0, eadfr_pkg::CH_ENQ, 1'b1, ACK_ONLY};
    directed[3]  = '{1'b0, 8'h02, 1'b0, NO_REPLY};
    directed[4]  = '{1'b0, eadfr_pkg::CH_DLE, 1'b0, NO_REPLY};
    directed[5]  = '{1'b0, eadfr_pkg::CH_ETX, 1'b0, NO_REPLY};
    directed[6]  = '{1'b0, eadfr_pkg::CH_DLE, 1'b0, NO_REPLY};
    directed[7]  = '{1'b0, eadfr_pkg::CH_DLE, 1'b0, NO_REPLY};
    directed[8]  = '{1'b0, 8'h00, 1'b0, NO_REPLY};
    directed[9]  = '{1'b0, eadfr_pkg::CH_ETX, 1'b0, NO_REPLY};
    // check byte equal to DLE, good sum
    directed[10] = '{1'b0, eadfr_pkg::CH_DLE, 1'b0, NO_REPLY};
    directed[11] = '{1'b0, 8'hFF, 1'b0, NO_REPLY};
    directed[12] = '{1'b0, eadfr_pkg::CH_ENQ, 1'b1, ACK_ONLY};
    directed[13] = '{1'b0, eadfr_pkg::CH_ETX, 1'b0, NO_REPLY};
    directed[14] = '{1'b0, eadfr_pkg::CH_DLE, 1'b1,
                     '{1'b1, eadfr_pkg::CH_NAK, 1'b0, 8'h00, eadfr_pkg::EV_BADCHECK, 8'h00}};
    // timeout 1, limit 2
    directed[15] = '{1'b0, eadfr_pkg::CH_ENQ, 1'b1, ACK_ONLY};
    directed[16] = '{1'b1, 8'hA5, 1'b1,
                     '{1'b0, 8'h00, 1'b0, 8'h00, eadfr_pkg::EV_TIMEOUT, 8'h00}};
    directed[17] = '{1'b0, eadfr_pkg::CH_ENQ, 1'b1, ACK_ONLY};
    directed[18] = '{1'b0, 8'h02, 1'b0, NO_REPLY};
    directed[19] = '{1'b0, eadfr_pkg::CH_DLE, 1'b0, NO_REPLY};
    directed[20] = '{1'b0, eadfr_pkg::CH_ENQ, 1'b1,
                     '{1'b1, eadfr_pkg::CH_NAK, 1'b1, eadfr_pkg::CH_ENQ,
                       eadfr_pkg::EV_OVERFLOW, 8'h00}};
    directed[21] = '{1'b0, eadfr_pkg::CH_ENQ, 1'b1, ACK_ONLY};
    directed[22] = '{1'b0, eadfr_pkg::CH_ETX, 1'b0, NO_REPLY};
    directed[23] = '{1'b0, 8'h00, 1'b0, NO_REPLY};
    directed[24] = '{1'b1, 8'h5A, 1'b1,
                     '{1'b0, 8'h00, 1'b0, 8'h00, eadfr_pkg::EV_DELIVERED, 8'h01}};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      if (i == PHASE_B_AT) begin
        settle();
        set_reg(eadfr_pkg::REG_TIMEOUT, 32'd1);
        set_reg(eadfr_pkg::REG_LIMIT, 32'd2);
      end
      send_item(directed[i].mode, directed[i].rx, directed[i].pinned, directed[i].want);
    end

    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin t_val = 16'hFFFF; l_val = 8'd255; end
        1: begin t_val = 16'd1; l_val = 8'd2; end
        5: begin t_val = eadfr_pkg::TIMEOUT_RESET; l_val = eadfr_pkg::LIMIT_RESET; end
        default: begin
          t_val = 16'($urandom_range(2, 24));
          l_val = 8'($urandom_range(3, 16));
        end
      endcase
      settle();
      set_reg(eadfr_pkg::REG_TIMEOUT, {16'h0000, t_val});
      set_reg(eadfr_pkg::REG_LIMIT, {24'h000000, l_val});
      case (seg / 2)
        0: begin send_idle_pct = 13; recv_idle_pct = 87; end
        1: begin send_idle_pct = 87; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // starve the sink while the sender keeps pushing, so the input stalls
      if (seg == 4) long_hold_arm <= 1'b1;
      plan_q.delete();
      cnt = 0;
      while (cnt < SEG_ITEMS || plan_q.size() != 0) begin
        if (plan_q.size() == 0) plan_frame();
        it = plan_q.pop_front();
        send_item(it.mode, it.rx, 1'b0, NO_REPLY);
        cnt++;
      end
    end

    item_valid <= 1'b0;
    @(posedge clk);
    for (i = 0; i < 20000 && pending_replies.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_replies.size() != 0)
      log_fault($sformatf("%0d expected results never arrived", pending_replies.size()));

    $display("run covered %0d beats, %0d results checked, %0d register settings",
             beats_in, replies_checked, reg_settings);
    $display("frame endings: %0d delivered, %0d bad check, %0d overflow, %0d timeout",
             ev_count[eadfr_pkg::EV_DELIVERED], ev_count[eadfr_pkg::EV_BADCHECK],
             ev_count[eadfr_pkg::EV_OVERFLOW], ev_count[eadfr_pkg::EV_TIMEOUT]);
    if (fault_count == 0) begin
      $display("** enq_ack_dle_frame_receiver: PASSED **");
    end else begin
      $display("** enq_ack_dle_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule
